// ----- rtl/pomf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pomf_pkg
// Shared types and constants for the port overheat mitigation core.
// ----------------------------------------------------------------------------
package pomf_pkg;

    localparam int InDataW  = 56;
    localparam int OutDataW = 120;
    localparam int CfgIdxW  = 2;
    localparam int CfgDataW = 16;

    // Register indexes on the configuration port
    localparam logic [CfgIdxW-1:0] REG_ENABLE   = 2'd0;
    localparam logic [CfgIdxW-1:0] REG_CLEAR_T  = 2'd1;
    localparam logic [CfgIdxW-1:0] REG_DIVIDER  = 2'd2;
    localparam logic [CfgIdxW-1:0] REG_ACC_WIN  = 2'd3;

    // Event codes
    localparam logic [1:0] EV_NONE    = 2'd0;
    localparam logic [1:0] EV_TRIPPED = 2'd1;
    localparam logic [1:0] EV_CLEARED = 2'd2;

    localparam logic signed [15:0] TEMP_NONE = 16'sh8000;

    localparam logic        ENABLE_RESET  = 1'b1;
    localparam logic [15:0] CLEAR_T_RESET = 16'd0;
    localparam logic [7:0]  DIVIDER_RESET = 8'd1;
    localparam logic [15:0] ACC_WIN_RESET = 16'd5;

    typedef struct packed {
        logic               enable;
        logic signed [15:0] clear_temperature;
        logic [7:0]         poll_divider;
        logic [15:0]        accessory_window_s;
    } cfg_t;

    typedef struct packed {
        logic               throttle_request;
        logic               port_present;
        logic               port_online;
        logic               sink_accessory;
        logic signed [15:0] port_temperature;
        logic [31:0]        now_seconds;
    } item_t;

    typedef struct packed {
        logic               mitigation_active;
        logic [1:0]         event_res;
        logic               keep_polling;
        logic               status_sampled;
        logic signed [15:0] event_plug_temperature;
        logic [31:0]        trip_delay_s;
        logic [31:0]        hysteresis_s;
        logic [31:0]        cleared_after_s;
    } res_t;

endpackage

// ----- rtl/pomf_engine.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pomf_engine
// Mitigation state and the per-poll decision logic; state updates when the
// buffered request moves into the result register.
// ----------------------------------------------------------------------------
module pomf_engine
(
    input  logic           clk,
    input  logic           rst_n,
    input  pomf_pkg::cfg_t  cfg,
    input  pomf_pkg::item_t item,
    input  logic           advance,
    output logic           busy,
    output pomf_pkg::res_t  res
);

    logic               mitigating_reg, mitigating_next;
    logic               replug_reg, replug_next;
    logic               connected_reg, connected_next;
    logic               accessory_reg, accessory_next;
    logic               online_reg, online_next;
    logic [7:0]         count_reg, count_next;
    logic [31:0]        plug_time_reg, plug_time_next;
    logic signed [15:0] conn_temp_reg, conn_temp_next;
    logic [31:0]        trip_time_reg, trip_time_next;
    logic [31:0]        cooldown_reg, cooldown_next;

    logic [7:0]  div_eff;
    logic [8:0]  count_inc;
    logic [7:0]  count_wrap;
    logic        too_hot;
    logic        sample_now;
    logic        prev_conn;
    logic        curr_conn;
    logic        keep;
    logic        acc_keep;
    logic [31:0] since_plug;

    assign div_eff = (cfg.poll_divider == 8'd0) ? 8'd1 : cfg.poll_divider;
    // A smaller divider written while idle leaves the counter out of range:
    // fold it back by repeated subtraction before the next request.
    assign busy = (count_reg >= div_eff);

    assign count_inc  = {1'b0, count_reg} + 9'd1;
    assign count_wrap = (count_inc == {1'b0, div_eff}) ? 8'd0 : count_inc[7:0];

    always_comb
    begin
        mitigating_next = mitigating_reg;
        replug_next     = replug_reg;
        connected_next  = connected_reg;
        accessory_next  = accessory_reg;
        online_next     = online_reg;
        count_next      = count_reg;
        plug_time_next  = plug_time_reg;
        conn_temp_next  = conn_temp_reg;
        trip_time_next  = trip_time_reg;
        cooldown_next   = cooldown_reg;
        sample_now      = 1'b1;
        prev_conn       = connected_reg | accessory_reg;
        curr_conn       = item.port_present | item.sink_accessory;
        keep            = 1'b0;
        acc_keep        = 1'b0;
        since_plug      = 32'd0;

        res.mitigation_active      = 1'b0;
        res.event_res              = pomf_pkg::EV_NONE;
        res.keep_polling           = 1'b0;
        res.status_sampled         = 1'b0;
        res.event_plug_temperature = pomf_pkg::TEMP_NONE;
        res.trip_delay_s           = 32'd0;
        res.hysteresis_s           = 32'd0;
        res.cleared_after_s        = 32'd0;

        too_hot = mitigating_reg && (item.port_temperature > cfg.clear_temperature);

        if (too_hot)
        begin
            keep = 1'b1;
        end
        else
        begin
            if (mitigating_reg)
            begin
                if (cooldown_reg == 32'd0)
                begin
                    cooldown_next = item.now_seconds;
                end
                count_next = count_wrap;
                sample_now = (count_wrap == 8'd0);
            end

            if (sample_now)
            begin
                res.status_sampled = 1'b1;
                online_next        = item.port_online;
                connected_next     = item.port_present;
                accessory_next     = item.sink_accessory;
                if (curr_conn && !prev_conn)
                begin
                    plug_time_next = item.now_seconds;
                    conn_temp_next = item.port_temperature;
                end
                if (mitigating_reg && !curr_conn && !prev_conn)
                begin
                    replug_next = 1'b1;
                end
            end

            if (mitigating_reg && (!cfg.enable || (!item.throttle_request && replug_next)))
            begin
                res.event_res              = pomf_pkg::EV_CLEARED;
                res.event_plug_temperature = conn_temp_next;
                res.trip_delay_s           = trip_time_reg - plug_time_next;
                res.hysteresis_s           = cooldown_next - trip_time_reg;
                res.cleared_after_s        = item.now_seconds - cooldown_next;
                conn_temp_next  = pomf_pkg::TEMP_NONE;
                plug_time_next  = 32'd0;
                trip_time_next  = 32'd0;
                cooldown_next   = 32'd0;
                mitigating_next = 1'b0;
                replug_next     = 1'b0;
            end
            else if (!mitigating_reg && cfg.enable && item.throttle_request)
            begin
                res.event_res   = pomf_pkg::EV_TRIPPED;
                replug_next     = 1'b0;
                trip_time_next  = item.now_seconds;
                mitigating_next = 1'b1;
                keep            = 1'b1;
            end

            if (!keep)
            begin
                since_plug = item.now_seconds - plug_time_next;
                acc_keep   = accessory_next && (since_plug < {16'd0, cfg.accessory_window_s});
                keep       = mitigating_next | online_next | acc_keep;
            end
        end

        res.mitigation_active = mitigating_next;
        res.keep_polling      = keep;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mitigating_reg <= 1'b0;
            replug_reg     <= 1'b0;
            connected_reg  <= 1'b0;
            accessory_reg  <= 1'b0;
            online_reg     <= 1'b0;
            count_reg      <= 8'd0;
            plug_time_reg  <= 32'd0;
            conn_temp_reg  <= pomf_pkg::TEMP_NONE;
            trip_time_reg  <= 32'd0;
            cooldown_reg   <= 32'd0;
        end
        else if (advance)
        begin
            mitigating_reg <= mitigating_next;
            replug_reg     <= replug_next;
            connected_reg  <= connected_next;
            accessory_reg  <= accessory_next;
            online_reg     <= online_next;
            count_reg      <= count_next;
            plug_time_reg  <= plug_time_next;
            conn_temp_reg  <= conn_temp_next;
            trip_time_reg  <= trip_time_next;
            cooldown_reg   <= cooldown_next;
        end
        else if (busy)
        begin
            count_reg <= count_reg - div_eff;
        end
    end

endmodule

// ----- rtl/port_overheat_mitigation_fsm_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// port_overheat_mitigation_fsm_core
// USB port overheat mitigation controller, one poll request per item.
// ----------------------------------------------------------------------------
// Each poll request passes an input register, the decision logic and a
// result register, so a new request is taken every cycle while the output is
// not stalled and no fold-back is running; its result is then held in the
// result register for the master side. The exception is a write of a smaller
// poll_divider: the sample counter is then folded back into range by one
// subtraction per cycle before the next request is processed; one request
// still waits in the input register meanwhile.
// ----------------------------------------------------------------------------
module port_overheat_mitigation_fsm_core
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // throttle_request, port_present, port_online, sink_accessory,
    // port_temperature, now_seconds, zero pad
    input  logic [pomf_pkg::InDataW-1:0]    s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // mitigation_active, event_res, keep_polling, status_sampled,
    // event_plug_temperature, trip_delay_s, hysteresis_s, cleared_after_s, zero pad
    output logic [pomf_pkg::OutDataW-1:0]   m_tdata,
    input  logic                            cfg_we,
    input  logic [pomf_pkg::CfgIdxW-1:0]    cfg_index,
    input  logic [pomf_pkg::CfgDataW-1:0]   cfg_wdata
);

    pomf_pkg::cfg_t  cfg_reg;
    pomf_pkg::item_t item_reg, item_next;
    pomf_pkg::res_t  res_reg, res_next;
    logic            in_valid_reg;
    logic            out_valid_reg;
    logic            out_free;
    logic            advance;
    logic            busy;

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free && !busy;
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;

    assign item_next.throttle_request = s_tdata[0];
    assign item_next.port_present     = s_tdata[1];
    assign item_next.port_online      = s_tdata[2];
    assign item_next.sink_accessory   = s_tdata[3];
    assign item_next.port_temperature = s_tdata[19:4];
    assign item_next.now_seconds      = s_tdata[51:20];

    assign m_tdata = {3'd0,
                      res_reg.cleared_after_s,
                      res_reg.hysteresis_s,
                      res_reg.trip_delay_s,
                      res_reg.event_plug_temperature,
                      res_reg.status_sampled,
                      res_reg.keep_polling,
                      res_reg.event_res,
                      res_reg.mitigation_active};

    pomf_engine u_engine
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .item    (item_reg),
        .advance (advance),
        .busy    (busy),
        .res     (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable             <= pomf_pkg::ENABLE_RESET;
            cfg_reg.clear_temperature  <= pomf_pkg::CLEAR_T_RESET;
            cfg_reg.poll_divider       <= pomf_pkg::DIVIDER_RESET;
            cfg_reg.accessory_window_s <= pomf_pkg::ACC_WIN_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                pomf_pkg::REG_ENABLE:  cfg_reg.enable             <= cfg_wdata[0];
                pomf_pkg::REG_CLEAR_T: cfg_reg.clear_temperature  <= cfg_wdata;
                pomf_pkg::REG_DIVIDER: cfg_reg.poll_divider       <= cfg_wdata[7:0];
                pomf_pkg::REG_ACC_WIN: cfg_reg.accessory_window_s <= cfg_wdata;
                default:               cfg_reg                    <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload: hold while stalled
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_reg <= item_next;
        end
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

endmodule
